### src/yrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrgb_pkg: shared types and constants
// Pixel transaction types, effect mode codes and the job descriptor that
// travels from the front end through the job queue to the back end.
// ----------------------------------------------------------------------------
package yrgb_pkg;

   localparam int FADE_FRAMES_DEFAULT = 300;
   localparam int WIPE_STEPS_DEFAULT  = 60;
   localparam int LINE_WIDTH_DEFAULT  = 352;

   localparam int PIX_W       = 8;
   localparam int COLUMN_W    = 10;
   localparam int FRAME_W     = 9;
   localparam int WIPE_W      = 6;
   // column * steps and wipe * width stay below 2^16 for the default parameters
   localparam int WIPE_PROD_W = 16;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_WIPE  = 2'd1,
      MODE_FADE  = 2'd2,
      MODE_DUAL  = 2'd3
   } effect_mode_type;

   typedef enum logic [1:0] {
      WIPE_VIDEO   = 2'd0,
      WIPE_OVERLAY = 2'd1,
      WIPE_WHITE   = 2'd2
   } wipe_sel_type;

   typedef struct packed {
      logic                frame_start;
      logic [COLUMN_W-1:0] column;
      logic [PIX_W-1:0]    luma_a;
      logic [PIX_W-1:0]    cb_a;
      logic [PIX_W-1:0]    cr_a;
      logic [PIX_W-1:0]    luma_b;
      logic [PIX_W-1:0]    cb_b;
      logic [PIX_W-1:0]    cr_b;
      logic [PIX_W-1:0]    overlay_red;
      logic [PIX_W-1:0]    overlay_green;
      logic [PIX_W-1:0]    overlay_blue;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] red_second;
      logic [PIX_W-1:0] green_second;
      logic [PIX_W-1:0] blue_second;
   } rsp_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] cb;
      logic [PIX_W-1:0] cr;
   } yuv_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      effect_mode_type    mode;
      wipe_sel_type       wipe_sel;
      logic [FRAME_W-1:0] frame_count;
      yuv_type            src_a;
      yuv_type            src_b;
      rgb_type            overlay;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### src/yrgb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrgb_queue: job queue
// Short register FIFO between the front end and the back end so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module yrgb_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  yrgb_pkg::job_type           push_job,
   input  logic                        pop,
   output yrgb_pkg::job_type           head_job,
   output yrgb_pkg::queue_status_type  status
);

   localparam int PTR_W = $clog2(yrgb_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(yrgb_pkg::QUEUE_DEPTH + 1);

   yrgb_pkg::job_type entry_ff [yrgb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(yrgb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(yrgb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(yrgb_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### src/yrgb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrgb_front: pixel intake
// Accepts pixel transactions, advances the frame counter and, in wipe mode, the
// wipe counter on the first pixel of a frame and resolves the wipe decision into a job.
// ----------------------------------------------------------------------------
module yrgb_front #(
   parameter int FADE_FRAMES = yrgb_pkg::FADE_FRAMES_DEFAULT,
   parameter int WIPE_STEPS  = yrgb_pkg::WIPE_STEPS_DEFAULT,
   parameter int LINE_WIDTH  = yrgb_pkg::LINE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  yrgb_pkg::effect_mode_type   effect_mode,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  yrgb_pkg::req_item_type      req_data,
   input  yrgb_pkg::queue_status_type  queue_status,
   output logic                        push,
   output yrgb_pkg::job_type           push_job
);

   logic [yrgb_pkg::FRAME_W-1:0]     frame_counter_ff, frame_counter_in;
   logic [yrgb_pkg::WIPE_W-1:0]      wipe_counter_ff, wipe_counter_in;
   logic                             accept;
   logic                             advance;
   logic [yrgb_pkg::WIPE_PROD_W-1:0] column_scaled;
   logic [yrgb_pkg::WIPE_PROD_W-1:0] wipe_scaled;
   logic                             overlay_lit;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign advance   = accept && req_data.frame_start;

   always_comb begin
      frame_counter_in = frame_counter_ff;
      wipe_counter_in  = wipe_counter_ff;
      if (advance) begin
         frame_counter_in = (frame_counter_ff == yrgb_pkg::FRAME_W'(FADE_FRAMES - 1)) ?
                            '0 : frame_counter_ff + 1'b1;
         if (effect_mode == yrgb_pkg::MODE_WIPE) begin
            wipe_counter_in = (wipe_counter_ff == yrgb_pkg::WIPE_W'(WIPE_STEPS)) ?
                              '0 : wipe_counter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_counter_ff <= '0;
         wipe_counter_ff  <= '0;
      end else begin
         frame_counter_ff <= frame_counter_in;
         wipe_counter_ff  <= wipe_counter_in;
      end
   end

   // compare against the updated counter: it applies to this very pixel
   assign column_scaled = yrgb_pkg::WIPE_PROD_W'(req_data.column) *
                          yrgb_pkg::WIPE_PROD_W'(WIPE_STEPS);
   assign wipe_scaled   = yrgb_pkg::WIPE_PROD_W'(wipe_counter_in) *
                          yrgb_pkg::WIPE_PROD_W'(LINE_WIDTH);
   assign overlay_lit   = (req_data.overlay_red != '0) || (req_data.overlay_green != '0) ||
                          (req_data.overlay_blue != '0);

   always_comb begin
      push_job.mode          = effect_mode;
      push_job.frame_count   = frame_counter_in;
      push_job.src_a.luma    = req_data.luma_a;
      push_job.src_a.cb      = req_data.cb_a;
      push_job.src_a.cr      = req_data.cr_a;
      push_job.src_b.luma    = req_data.luma_b;
      push_job.src_b.cb      = req_data.cb_b;
      push_job.src_b.cr      = req_data.cr_b;
      push_job.overlay.red   = req_data.overlay_red;
      push_job.overlay.green = req_data.overlay_green;
      push_job.overlay.blue  = req_data.overlay_blue;
      if (!overlay_lit) begin
         push_job.wipe_sel = yrgb_pkg::WIPE_VIDEO;
      end else if (column_scaled < wipe_scaled) begin
         push_job.wipe_sel = yrgb_pkg::WIPE_OVERLAY;
      end else begin
         push_job.wipe_sel = yrgb_pkg::WIPE_WHITE;
      end
   end

   assign push = accept;

endmodule

### src/yrgb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrgb_back: conversion and composition pipeline
// Five stages: BT.601 products, sum and clamp, fade products, fade sum,
// reciprocal multiply; then the output register composes the pixel.
// ----------------------------------------------------------------------------
module yrgb_back #(
   parameter int FADE_FRAMES = yrgb_pkg::FADE_FRAMES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  yrgb_pkg::queue_status_type  queue_status,
   output logic                        pop,
   input  yrgb_pkg::job_type           head_job,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output yrgb_pkg::rsp_item_type      rsp_data
);

   localparam int ACC_W = 20;
   localparam logic signed [ACC_W-1:0] OFS_Y = 20'sd16;
   localparam logic signed [ACC_W-1:0] OFS_C = 20'sd128;
   localparam logic signed [ACC_W-1:0] RND   = 20'sd128;
   localparam logic signed [ACC_W-1:0] K298  = 20'sd298;
   localparam logic signed [ACC_W-1:0] K409  = 20'sd409;
   localparam logic signed [ACC_W-1:0] K100  = 20'sd100;
   localparam logic signed [ACC_W-1:0] K208  = 20'sd208;
   localparam logic signed [ACC_W-1:0] K516  = 20'sd516;

   localparam int WPROD_W     = yrgb_pkg::PIX_W + yrgb_pkg::FRAME_W;
   localparam int SUM_W       = $clog2(255 * FADE_FRAMES + 1);
   localparam int RECIP_SHIFT = SUM_W + $clog2(FADE_FRAMES);
   localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + FADE_FRAMES - 1) / FADE_FRAMES;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int QPROD_W     = RECIP_SHIFT + yrgb_pkg::PIX_W;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

   typedef struct packed {
      logic signed [ACC_W-1:0] y298;
      logic signed [ACC_W-1:0] v409;
      logic signed [ACC_W-1:0] u100;
      logic signed [ACC_W-1:0] v208;
      logic signed [ACC_W-1:0] u516;
   } prod_type;

   typedef struct packed {
      yrgb_pkg::effect_mode_type mode;
      yrgb_pkg::wipe_sel_type    wipe_sel;
      yrgb_pkg::rgb_type         overlay;
      yrgb_pkg::rgb_type         rgb_a;
      yrgb_pkg::rgb_type         rgb_b;
   } side_type;

   typedef struct packed {
      logic [WPROD_W-1:0] red;
      logic [WPROD_W-1:0] green;
      logic [WPROD_W-1:0] blue;
   } wprod_type;

   function automatic prod_type mul_yuv(input yrgb_pkg::yuv_type s);
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] u;
      logic signed [ACC_W-1:0] v;
      prod_type                p;
      y = signed'(ACC_W'(s.luma)) - OFS_Y;
      u = signed'(ACC_W'(s.cb)) - OFS_C;
      v = signed'(ACC_W'(s.cr)) - OFS_C;
      p.y298 = y * K298;
      p.v409 = v * K409;
      p.u100 = u * K100;
      p.v208 = v * K208;
      p.u516 = u * K516;
      return p;
   endfunction

   function automatic logic [yrgb_pkg::PIX_W-1:0] clamp8(input logic signed [ACC_W-1:0] acc);
      logic [yrgb_pkg::PIX_W-1:0] r;
      if (acc[ACC_W-1]) begin
         r = '0;
      end else if (acc[ACC_W-2:16] != '0) begin
         r = '1;
      end else begin
         r = acc[15:8];
      end
      return r;
   endfunction

   function automatic yrgb_pkg::rgb_type sum_rgb(input prod_type p);
      yrgb_pkg::rgb_type c;
      c.red   = clamp8(p.y298 + p.v409 + RND);
      c.green = clamp8(p.y298 - p.u100 - p.v208 + RND);
      c.blue  = clamp8(p.y298 + p.u516 + RND);
      return c;
   endfunction

   logic advance;

   // stage 1: conversion products
   logic                        s1_valid_ff, s1_valid_in;
   prod_type                    s1_prod_a_ff, s1_prod_b_ff;
   yrgb_pkg::effect_mode_type   s1_mode_ff;
   yrgb_pkg::wipe_sel_type      s1_sel_ff;
   yrgb_pkg::rgb_type           s1_overlay_ff;
   logic [yrgb_pkg::FRAME_W-1:0] s1_count_ff;

   // stage 2: clamped RGB and fade weights
   logic                        s2_valid_ff, s2_valid_in;
   side_type                    s2_side_ff;
   logic [yrgb_pkg::FRAME_W-1:0] s2_weight_a_ff, s2_weight_b_ff;

   // stage 3: fade products
   logic                        s3_valid_ff, s3_valid_in;
   side_type                    s3_side_ff;
   wprod_type                   s3_pa_ff, s3_pb_ff;

   // stage 4: fade sums
   logic                        s4_valid_ff, s4_valid_in;
   side_type                    s4_side_ff;
   logic [SUM_W-1:0]            s4_sum_r_ff, s4_sum_g_ff, s4_sum_b_ff;

   // stage 5: reciprocal products
   logic                        s5_valid_ff, s5_valid_in;
   side_type                    s5_side_ff;
   logic [QPROD_W-1:0]          s5_q_r_ff, s5_q_g_ff, s5_q_b_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   yrgb_pkg::rsp_item_type      rsp_data_ff, rsp_data_in;
   yrgb_pkg::rgb_type           fade_rgb;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && !queue_status.empty;

   assign s1_valid_in  = advance ? pop         : s1_valid_ff;
   assign s2_valid_in  = advance ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = advance ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in  = advance ? s3_valid_ff : s4_valid_ff;
   assign s5_valid_in  = advance ? s4_valid_ff : s5_valid_ff;
   assign rsp_valid_in = advance ? s5_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_a_ff  <= mul_yuv(head_job.src_a);
         s1_prod_b_ff  <= mul_yuv(head_job.src_b);
         s1_mode_ff    <= head_job.mode;
         s1_sel_ff     <= head_job.wipe_sel;
         s1_overlay_ff <= head_job.overlay;
         s1_count_ff   <= head_job.frame_count;

         s2_side_ff.mode     <= s1_mode_ff;
         s2_side_ff.wipe_sel <= s1_sel_ff;
         s2_side_ff.overlay  <= s1_overlay_ff;
         s2_side_ff.rgb_a    <= sum_rgb(s1_prod_a_ff);
         s2_side_ff.rgb_b    <= sum_rgb(s1_prod_b_ff);
         s2_weight_a_ff      <= yrgb_pkg::FRAME_W'(FADE_FRAMES) - s1_count_ff;
         s2_weight_b_ff      <= s1_count_ff;

         s3_side_ff     <= s2_side_ff;
         s3_pa_ff.red   <= WPROD_W'(s2_side_ff.rgb_a.red)   * WPROD_W'(s2_weight_a_ff);
         s3_pa_ff.green <= WPROD_W'(s2_side_ff.rgb_a.green) * WPROD_W'(s2_weight_a_ff);
         s3_pa_ff.blue  <= WPROD_W'(s2_side_ff.rgb_a.blue)  * WPROD_W'(s2_weight_a_ff);
         s3_pb_ff.red   <= WPROD_W'(s2_side_ff.rgb_b.red)   * WPROD_W'(s2_weight_b_ff);
         s3_pb_ff.green <= WPROD_W'(s2_side_ff.rgb_b.green) * WPROD_W'(s2_weight_b_ff);
         s3_pb_ff.blue  <= WPROD_W'(s2_side_ff.rgb_b.blue)  * WPROD_W'(s2_weight_b_ff);

         s4_side_ff  <= s3_side_ff;
         s4_sum_r_ff <= SUM_W'({1'b0, s3_pa_ff.red}   + {1'b0, s3_pb_ff.red});
         s4_sum_g_ff <= SUM_W'({1'b0, s3_pa_ff.green} + {1'b0, s3_pb_ff.green});
         s4_sum_b_ff <= SUM_W'({1'b0, s3_pa_ff.blue}  + {1'b0, s3_pb_ff.blue});

         // exact floor division by FADE_FRAMES through a rounded-up reciprocal
         s5_side_ff <= s4_side_ff;
         s5_q_r_ff  <= QPROD_W'(s4_sum_r_ff) * QPROD_W'(RECIP_V);
         s5_q_g_ff  <= QPROD_W'(s4_sum_g_ff) * QPROD_W'(RECIP_V);
         s5_q_b_ff  <= QPROD_W'(s4_sum_b_ff) * QPROD_W'(RECIP_V);
      end
   end

   assign fade_rgb.red   = s5_q_r_ff[RECIP_SHIFT +: yrgb_pkg::PIX_W];
   assign fade_rgb.green = s5_q_g_ff[RECIP_SHIFT +: yrgb_pkg::PIX_W];
   assign fade_rgb.blue  = s5_q_b_ff[RECIP_SHIFT +: yrgb_pkg::PIX_W];

   always_comb begin
      rsp_data_in.red          = s5_side_ff.rgb_a.red;
      rsp_data_in.green        = s5_side_ff.rgb_a.green;
      rsp_data_in.blue         = s5_side_ff.rgb_a.blue;
      rsp_data_in.red_second   = '0;
      rsp_data_in.green_second = '0;
      rsp_data_in.blue_second  = '0;
      unique case (s5_side_ff.mode)
         yrgb_pkg::MODE_PLAIN: begin
         end
         yrgb_pkg::MODE_WIPE: begin
            unique case (s5_side_ff.wipe_sel)
               yrgb_pkg::WIPE_VIDEO: begin
               end
               yrgb_pkg::WIPE_OVERLAY: begin
                  rsp_data_in.red   = s5_side_ff.overlay.red;
                  rsp_data_in.green = s5_side_ff.overlay.green;
                  rsp_data_in.blue  = s5_side_ff.overlay.blue;
               end
               default: begin
                  rsp_data_in.red   = '1;
                  rsp_data_in.green = '1;
                  rsp_data_in.blue  = '1;
               end
            endcase
         end
         yrgb_pkg::MODE_FADE: begin
            rsp_data_in.red   = fade_rgb.red;
            rsp_data_in.green = fade_rgb.green;
            rsp_data_in.blue  = fade_rgb.blue;
         end
         yrgb_pkg::MODE_DUAL: begin
            rsp_data_in.red_second   = s5_side_ff.rgb_b.red;
            rsp_data_in.green_second = s5_side_ff.rgb_b.green;
            rsp_data_in.blue_second  = s5_side_ff.rgb_b.blue;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance && s5_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/yuv420_to_rgb_with_fade_and_wipe.sv
`timescale 1ns / 1ps
// An accepted pixel passes the job queue, 5 pipeline stages and the output
// register. Throughput: one pixel per clock unless the result side stalls;
// a 4-entry job queue decouples the intake from the pipeline, which advances
// whenever its output register can take data.
// Reset (synchronous, active high) clears the effect mode, both counters, the
// queue and all pipeline valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
// yuv420_to_rgb_with_fade_and_wipe: YUV to RGB converter with effects
// Converts two YUV sources with integer BT.601 and composes plain, overlay
// wipe, crossfade or dual output pixels.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_with_fade_and_wipe #(
   parameter int FADE_FRAMES = yrgb_pkg::FADE_FRAMES_DEFAULT,
   parameter int WIPE_STEPS  = yrgb_pkg::WIPE_STEPS_DEFAULT,
   parameter int LINE_WIDTH  = yrgb_pkg::LINE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_write_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  yrgb_pkg::req_item_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output yrgb_pkg::rsp_item_type  rsp_data
);

   yrgb_pkg::effect_mode_type   effect_mode_ff, effect_mode_in;
   yrgb_pkg::queue_status_type  queue_status;
   yrgb_pkg::job_type           push_job;
   yrgb_pkg::job_type           head_job;
   logic                        push;
   logic                        pop;

   assign effect_mode_in = csr_write_enable ? yrgb_pkg::effect_mode_type'(csr_write_data) :
                           effect_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_mode_ff <= yrgb_pkg::MODE_PLAIN;
      end else begin
         effect_mode_ff <= effect_mode_in;
      end
   end

   yrgb_front #(
      .FADE_FRAMES (FADE_FRAMES),
      .WIPE_STEPS  (WIPE_STEPS),
      .LINE_WIDTH  (LINE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .effect_mode  (effect_mode_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   yrgb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (queue_status)
   );

   yrgb_back #(
      .FADE_FRAMES (FADE_FRAMES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop          (pop),
      .head_job     (head_job),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

### dv/tb_yuv420_to_rgb_with_fade_and_wipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv420_to_rgb_with_fade_and_wipe: self-checking pixel stream bench
// Streams directed and random YUV pixel pairs with overlay pixels through the
// converter in every effect mode. A scoreboard class models the BT.601
// conversion, the frame and wipe counters and the mode composition, and checks
// each result pixel in order. Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------

class pixel_scoreboard;
   yrgb_pkg::effect_mode_type mode;
   int unsigned               frame_cnt;
   int unsigned               wipe_cnt;
   yrgb_pkg::rsp_item_type    expected_q[$];
   int unsigned               mismatches;
   int unsigned               checked;
   int unsigned               mode_items[4];
   int unsigned               frame_starts;
   int unsigned               fade_wraps;
   int unsigned               wipe_wraps;

   function new();
      mode         = yrgb_pkg::MODE_PLAIN;
      frame_cnt    = 0;
      wipe_cnt     = 0;
      mismatches   = 0;
      checked      = 0;
      frame_starts = 0;
      fade_wraps   = 0;
      wipe_wraps   = 0;
      foreach (mode_items[i]) mode_items[i] = 0;
   endfunction

   function void set_mode(yrgb_pkg::effect_mode_type m);
      mode = m;
   endfunction

   function logic [7:0] sat8(int acc);
      if (acc < 0) return 8'd0;
      if ((acc >>> 8) > 255) return 8'd255;
      return 8'(acc >>> 8);
   endfunction

   function yrgb_pkg::rgb_type to_rgb(logic [7:0] y8, logic [7:0] u8, logic [7:0] v8);
      int                y;
      int                u;
      int                v;
      yrgb_pkg::rgb_type c;
      y       = int'(y8) - 16;
      u       = int'(u8) - 128;
      v       = int'(v8) - 128;
      c.red   = sat8(298 * y + 409 * v + 128);
      c.green = sat8(298 * y - 100 * u - 208 * v + 128);
      c.blue  = sat8(298 * y + 516 * u + 128);
      return c;
   endfunction

   function logic [7:0] blend(logic [7:0] a, logic [7:0] b, int n);
      int f;
      f = yrgb_pkg::FADE_FRAMES_DEFAULT;
      return 8'((int'(a) * (f - n) + int'(b) * n) / f);
   endfunction

   // Advance counters first, then compose the pixel for the current mode
   function void note_pixel(yrgb_pkg::req_item_type px);
      yrgb_pkg::rgb_type      a;
      yrgb_pkg::rgb_type      b;
      yrgb_pkg::rsp_item_type want;
      if (px.frame_start) begin
         frame_starts++;
         frame_cnt++;
         if (frame_cnt > yrgb_pkg::FADE_FRAMES_DEFAULT - 1) begin
            frame_cnt = 0;
            fade_wraps++;
         end
         if (mode == yrgb_pkg::MODE_WIPE) begin
            wipe_cnt++;
            if (wipe_cnt > yrgb_pkg::WIPE_STEPS_DEFAULT) begin
               wipe_cnt = 0;
               wipe_wraps++;
            end
         end
      end
      a          = to_rgb(px.luma_a, px.cb_a, px.cr_a);
      b          = to_rgb(px.luma_b, px.cb_b, px.cr_b);
      want       = '0;
      want.red   = a.red;
      want.green = a.green;
      want.blue  = a.blue;
      case (mode)
         yrgb_pkg::MODE_WIPE: begin
            if ((px.overlay_red | px.overlay_green | px.overlay_blue) != 8'd0) begin
               if (int'(px.column) * yrgb_pkg::WIPE_STEPS_DEFAULT <
                   int'(wipe_cnt) * yrgb_pkg::LINE_WIDTH_DEFAULT) begin
                  want.red   = px.overlay_red;
                  want.green = px.overlay_green;
                  want.blue  = px.overlay_blue;
               end else begin
                  want.red   = 8'd255;
                  want.green = 8'd255;
                  want.blue  = 8'd255;
               end
            end
         end
         yrgb_pkg::MODE_FADE: begin
            want.red   = blend(a.red, b.red, frame_cnt);
            want.green = blend(a.green, b.green, frame_cnt);
            want.blue  = blend(a.blue, b.blue, frame_cnt);
         end
         yrgb_pkg::MODE_DUAL: begin
            want.red_second   = b.red;
            want.green_second = b.green;
            want.blue_second  = b.blue;
         end
         default: ;
      endcase
      mode_items[int'(mode)]++;
      expected_q.push_back(want);
   endfunction

   function void check_pixel(yrgb_pkg::rsp_item_type got);
      yrgb_pkg::rsp_item_type want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected pixel %0d,%0d,%0d / %0d,%0d,%0d", got.red, got.green,
                     got.blue, got.red_second, got.green_second, got.blue_second);
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.red_second !== want.red_second || got.green_second !== want.green_second ||
          got.blue_second !== want.blue_second) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: pixel %0d want %0d,%0d,%0d / %0d,%0d,%0d got %0d,%0d,%0d / %0d,%0d,%0d",
                     checked, want.red, want.green, want.blue, want.red_second,
                     want.green_second, want.blue_second, got.red, got.green, got.blue,
                     got.red_second, got.green_second, got.blue_second);
      end
   endfunction
endclass

module tb_yuv420_to_rgb_with_fade_and_wipe;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int          RANDOM_PHASES = 8;
   localparam int          PHASE_PIXELS  = 200;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [1:0]             csr_write_data;
   logic                   req_valid;
   logic                   req_ready;
   yrgb_pkg::req_item_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   yrgb_pkg::rsp_item_type rsp_data;

   pixel_scoreboard sb;
   int              idle_pct;
   int unsigned     cycles = 0;

   yrgb_pkg::effect_mode_type phase_modes[RANDOM_PHASES] = '{
      yrgb_pkg::MODE_WIPE, yrgb_pkg::MODE_FADE, yrgb_pkg::MODE_DUAL, yrgb_pkg::MODE_PLAIN,
      yrgb_pkg::MODE_WIPE, yrgb_pkg::MODE_FADE, yrgb_pkg::MODE_WIPE, yrgb_pkg::MODE_DUAL};
   int              phase_idle[RANDOM_PHASES] = '{20, 5, 20, 0, 20, 5, 20, 0};

   yuv420_to_rgb_with_fade_and_wipe DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_pixel(rsp_data);
   end

   // Result side backpressure: random stall bursts, none when idle_pct is zero
   initial begin
      forever begin
         @(posedge clock);
         if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 2) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic yrgb_pkg::req_item_type make_pixel(bit fs, int col, int ya, int ua,
                                                         int va, int yb, int ub, int vb,
                                                         int ovr, int ovg, int ovb);
      yrgb_pkg::req_item_type px;
      px.frame_start   = fs;
      px.column        = 10'(col);
      px.luma_a        = 8'(ya);
      px.cb_a          = 8'(ua);
      px.cr_a          = 8'(va);
      px.luma_b        = 8'(yb);
      px.cb_b          = 8'(ub);
      px.cr_b          = 8'(vb);
      px.overlay_red   = 8'(ovr);
      px.overlay_green = 8'(ovg);
      px.overlay_blue  = 8'(ovb);
      return px;
   endfunction

   function automatic logic [7:0] rand_sample();
      case ($urandom_range(0, 15))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd16;
         3: return 8'd235;
         4: return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Bias columns toward the visible line and the current wipe edge
   function automatic yrgb_pkg::req_item_type random_pixel(int wipe);
      yrgb_pkg::req_item_type px;
      int                     edge_col;
      int                     col;
      edge_col = (wipe * yrgb_pkg::LINE_WIDTH_DEFAULT + yrgb_pkg::WIPE_STEPS_DEFAULT - 1) /
                 yrgb_pkg::WIPE_STEPS_DEFAULT;
      case ($urandom_range(0, 3))
         0: col = $urandom_range(0, 1023);
         1: col = $urandom_range(0, yrgb_pkg::LINE_WIDTH_DEFAULT - 1);
         2: col = edge_col - 1 + $urandom_range(0, 2);
         default: begin
            case ($urandom_range(0, 3))
               0: col = 0;
               1: col = 1023;
               2: col = yrgb_pkg::LINE_WIDTH_DEFAULT - 1;
               default: col = yrgb_pkg::LINE_WIDTH_DEFAULT;
            endcase
         end
      endcase
      if (col < 0) col = 0;
      if (col > 1023) col = 1023;
      px.frame_start = ($urandom_range(0, 2) == 0);
      px.column      = 10'(col);
      px.luma_a      = rand_sample();
      px.cb_a        = rand_sample();
      px.cr_a        = rand_sample();
      px.luma_b      = rand_sample();
      px.cb_b        = rand_sample();
      px.cr_b        = rand_sample();
      case ($urandom_range(0, 3))
         0: begin
            px.overlay_red   = 8'd0;
            px.overlay_green = 8'd0;
            px.overlay_blue  = 8'd0;
         end
         1: begin
            px.overlay_red   = 8'd0;
            px.overlay_green = 8'd0;
            px.overlay_blue  = 8'd0;
            case ($urandom_range(0, 2))
               0: px.overlay_red = 8'($urandom_range(1, 255));
               1: px.overlay_green = 8'($urandom_range(1, 255));
               default: px.overlay_blue = 8'($urandom_range(1, 255));
            endcase
         end
         default: begin
            px.overlay_red   = rand_sample();
            px.overlay_green = rand_sample();
            px.overlay_blue  = rand_sample();
         end
      endcase
      return px;
   endfunction

   // Hold valid across back-to-back transactions; drop it only for an idle burst
   task automatic send_pixel(input yrgb_pkg::req_item_type px);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(px);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_mode(input yrgb_pkg::effect_mode_type m);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_mode(m);
   endtask

   initial begin
      int unsigned failures;
      sb               = new();
      idle_pct         = 0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= yrgb_pkg::MODE_PLAIN;
      req_valid        <= 1'b0;
      req_data         <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Plain: field extremes, black, white and clamping on both ends
      write_mode(yrgb_pkg::MODE_PLAIN);
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(0, 1023, 255, 255, 255, 255, 255, 255, 255, 255, 255));
      send_pixel(make_pixel(0, 5, 16, 128, 128, 235, 128, 128, 1, 2, 3));
      send_pixel(make_pixel(0, 6, 255, 0, 255, 0, 255, 0, 0, 0, 0));
      send_pixel(make_pixel(0, 7, 0, 255, 0, 255, 0, 255, 7, 0, 0));
      wait_drained();

      // Wipe: black overlay passes video, overlay left of the edge, white beyond
      write_mode(yrgb_pkg::MODE_WIPE);
      send_pixel(make_pixel(1, 0, 100, 90, 200, 0, 0, 0, 0, 0, 0));
      send_pixel(make_pixel(0, 0, 100, 90, 200, 0, 0, 0, 10, 20, 30));
      send_pixel(make_pixel(0, 6, 60, 200, 30, 0, 0, 0, 255, 0, 0));
      send_pixel(make_pixel(0, 5, 60, 200, 30, 0, 0, 0, 0, 0, 1));
      send_pixel(make_pixel(1, 1023, 60, 200, 30, 0, 0, 0, 0, 1, 0));
      send_pixel(make_pixel(0, 11, 60, 200, 30, 0, 0, 0, 255, 255, 255));
      wait_drained();

      // Fade: blends of the two sources at opposite extremes
      write_mode(yrgb_pkg::MODE_FADE);
      send_pixel(make_pixel(1, 0, 255, 128, 128, 16, 128, 128, 0, 0, 0));
      send_pixel(make_pixel(0, 1, 0, 0, 0, 255, 255, 255, 0, 0, 0));
      send_pixel(make_pixel(1, 2, 255, 255, 255, 0, 0, 0, 9, 9, 9));
      send_pixel(make_pixel(0, 3, 180, 60, 200, 40, 220, 30, 0, 0, 0));
      wait_drained();

      // Dual: second source on the extra fields
      write_mode(yrgb_pkg::MODE_DUAL);
      send_pixel(make_pixel(0, 0, 16, 128, 128, 235, 128, 128, 0, 0, 0));
      send_pixel(make_pixel(1, 1023, 255, 0, 0, 0, 255, 255, 255, 255, 255));
      send_pixel(make_pixel(0, 512, 81, 90, 240, 145, 54, 34, 0, 0, 0));
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idle_pct = phase_idle[p];
         write_mode(phase_modes[p]);
         for (int i = 0; i < PHASE_PIXELS; i++)
            send_pixel(random_pixel(int'(sb.wipe_cnt)));
         wait_drained();
      end

      failures = sb.mismatches + sb.expected_q.size();
      $display("Checked %0d pixels: plain %0d, wipe %0d, fade %0d, dual %0d.", sb.checked,
               sb.mode_items[0], sb.mode_items[1], sb.mode_items[2], sb.mode_items[3]);
      $display("Frame starts %0d, fade counter wraps %0d, wipe counter wraps %0d, errors %0d.",
               sb.frame_starts, sb.fade_wraps, sb.wipe_wraps, failures);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
